// ----- hdl/pdi_pkg.sv -----
package pdi_pkg;

	localparam int WORD_BITS   = 48;
	localparam int FRAC_BITS   = 24;
	localparam int CFG_BITS    = 32;
	localparam int COUNT_BITS  = 32;
	localparam int ENERGY_BITS = WORD_BITS + 9;
	localparam int IDX_BITS    = 2;

	localparam int G_FRAC      = 24;
	localparam int DT_FRAC     = 32;
	localparam int DRAG_FRAC   = 40;
	localparam int FACTOR_FRAC = 48;

	localparam int MUL_BITS    = 64;
	localparam int PROD_BITS   = 2 * MUL_BITS;
	localparam int WIDE_BITS   = 82;
	localparam int SQ_SUM_BITS = 2 * WORD_BITS + 1;
	localparam int RAD_BITS    = SQ_SUM_BITS + 1;
	localparam int ROOT_BITS   = RAD_BITS / 2;

	localparam logic [IDX_BITS-1:0] REG_GRAVITY   = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_TIME_STEP = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_DRAG      = 2'd2;

	localparam logic [CFG_BITS-1:0] GRAVITY_RST   = 32'd164584489;
	localparam logic [CFG_BITS-1:0] TIME_STEP_RST = 32'd21474836;
	localparam logic [CFG_BITS-1:0] DRAG_RST      = 32'd43980465;

	localparam logic IN_LAUNCH = 1'b0;
	localparam logic IN_TICK   = 1'b1;

	typedef enum logic [3:0] {
		OP_NONE, OP_VXX, OP_VYY, OP_EY, OP_SQRT, OP_P, OP_F,
		OP_G, OP_TX, OP_TY, OP_PX, OP_PY
	} pdi_op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_VXX, ST_VYY, ST_EY, ST_EMIT, ST_SQRT, ST_P, ST_F,
		ST_G, ST_TX, ST_TY, ST_PX, ST_PY, ST_COMMIT
	} pdi_state_t;

	typedef struct packed {
		logic    load;
		logic    start;
		logic    capture;
		logic    emit;
		logic    commit;
		pdi_op_t op;
	} pdi_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic sqrt_done;
		logic out_free;
		logic advance;
	} pdi_status_t;

	function automatic logic [WORD_BITS-1:0] mag_word(input logic [WORD_BITS-1:0] v);
		return v[WORD_BITS-1] ? WORD_BITS'(-v) : v;
	endfunction

	function automatic logic [WORD_BITS-1:0] sat_word(input logic [WIDE_BITS-1:0] v);
		if (v[WIDE_BITS-1:WORD_BITS-1] == '0 || v[WIDE_BITS-1:WORD_BITS-1] == '1)
			return v[WORD_BITS-1:0];
		else if (v[WIDE_BITS-1])
			return {1'b1, {(WORD_BITS-1){1'b0}}};
		else
			return {1'b0, {(WORD_BITS-1){1'b1}}};
	endfunction

	function automatic logic [ENERGY_BITS-1:0] sat_energy(input logic [WIDE_BITS-1:0] v);
		if (v[WIDE_BITS-1:ENERGY_BITS-1] == '0 || v[WIDE_BITS-1:ENERGY_BITS-1] == '1)
			return v[ENERGY_BITS-1:0];
		else if (v[WIDE_BITS-1])
			return {1'b1, {(ENERGY_BITS-1){1'b0}}};
		else
			return {1'b0, {(ENERGY_BITS-1){1'b1}}};
	endfunction

endpackage

// ----- hdl/pdi_mul.sv -----
// 64x64 unsigned multiply, one 32x32 partial product per cycle
module pdi_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pdi_pkg::MUL_BITS-1:0]   a,
	input  logic [pdi_pkg::MUL_BITS-1:0]   b,
	output logic                           busy,
	output logic                           done,
	output logic [pdi_pkg::PROD_BITS-1:0]  p
);
	localparam int H = pdi_pkg::MUL_BITS / 2;

	logic [pdi_pkg::MUL_BITS-1:0]  a_q, b_q;
	logic [2:0]                    iss_q;
	logic                          act_q, done_q, pp_v_s1;
	logic [pdi_pkg::MUL_BITS-1:0]  pp_s1;
	logic [1:0]                    sh_s1;
	logic [pdi_pkg::PROD_BITS-1:0] acc_q;
	logic [H-1:0]                  a_half, b_half;

	assign a_half = iss_q[1] ? a_q[2*H-1:H] : a_q[H-1:0];
	assign b_half = iss_q[0] ? b_q[2*H-1:H] : b_q[H-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= 1'b0;
			done_q  <= 1'b0;
			iss_q   <= '0;
			pp_v_s1 <= 1'b0;
		end else if (start) begin
			act_q   <= 1'b1;
			done_q  <= 1'b0;
			iss_q   <= '0;
			pp_v_s1 <= 1'b0;
		end else if (act_q) begin
			if (iss_q != 3'd4) begin
				pp_v_s1 <= 1'b1;
				iss_q   <= iss_q + 3'd1;
			end else begin
				pp_v_s1 <= 1'b0;
			end
			if (iss_q == 3'd4 && pp_v_s1) begin
				done_q <= 1'b1;
				act_q  <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (act_q) begin
			if (iss_q != 3'd4) begin
				pp_s1 <= a_half * b_half;
				sh_s1 <= {1'b0, iss_q[1]} + {1'b0, iss_q[0]};
			end
			if (pp_v_s1)
				acc_q <= acc_q + ({{pdi_pkg::MUL_BITS{1'b0}}, pp_s1} << {sh_s1, 5'b0});
		end
	end

	assign busy = act_q;
	assign done = done_q;
	assign p    = acc_q;

endmodule

// ----- hdl/pdi_sqrt.sv -----
// restoring integer square root, one result bit per cycle
module pdi_sqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pdi_pkg::RAD_BITS-1:0]   rad,
	output logic                           busy,
	output logic                           done,
	output logic [pdi_pkg::ROOT_BITS-1:0]  root
);
	localparam int RB = pdi_pkg::ROOT_BITS;
	localparam int CW = $clog2(RB);

	logic [pdi_pkg::RAD_BITS-1:0] rad_q;
	logic [RB+1:0]                rem_q;
	logic [RB-1:0]                root_q;
	logic [CW-1:0]                cnt_q;
	logic                         act_q, done_q;
	logic [RB+3:0]                rem_t, trial;
	logic                         ge;

	assign rem_t = {rem_q, rad_q[pdi_pkg::RAD_BITS-1:pdi_pkg::RAD_BITS-2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = rem_t >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			act_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (act_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(RB - 1)) begin
				act_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (act_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? (RB+2)'(rem_t - trial) : rem_t[RB+1:0];
			root_q <= {root_q[RB-2:0], ge};
		end
	end

	assign busy = act_q;
	assign done = done_q;
	assign root = root_q;

endmodule

// ----- hdl/pdi_ctrl.sv -----
module pdi_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  pdi_pkg::pdi_status_t status,
	output pdi_pkg::pdi_cmd_t    cmd,
	output logic                 in_stall
);
	pdi_pkg::pdi_state_t state_q, state_d;
	logic                started_q;
	logic                unit_done;

	assign unit_done = (state_q == pdi_pkg::ST_SQRT) ? status.sqrt_done : status.mul_done;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pdi_pkg::ST_IDLE:   if (in_valid) state_d = pdi_pkg::ST_VXX;
			pdi_pkg::ST_VXX:    if (unit_done) state_d = pdi_pkg::ST_VYY;
			pdi_pkg::ST_VYY:    if (unit_done) state_d = pdi_pkg::ST_EY;
			pdi_pkg::ST_EY:     if (unit_done) state_d = pdi_pkg::ST_EMIT;
			pdi_pkg::ST_EMIT: begin
				if (status.out_free)
					state_d = status.advance ? pdi_pkg::ST_SQRT : pdi_pkg::ST_IDLE;
			end
			pdi_pkg::ST_SQRT:   if (unit_done) state_d = pdi_pkg::ST_P;
			pdi_pkg::ST_P:      if (unit_done) state_d = pdi_pkg::ST_F;
			pdi_pkg::ST_F:      if (unit_done) state_d = pdi_pkg::ST_G;
			pdi_pkg::ST_G:      if (unit_done) state_d = pdi_pkg::ST_TX;
			pdi_pkg::ST_TX:     if (unit_done) state_d = pdi_pkg::ST_TY;
			pdi_pkg::ST_TY:     if (unit_done) state_d = pdi_pkg::ST_PX;
			pdi_pkg::ST_PX:     if (unit_done) state_d = pdi_pkg::ST_PY;
			pdi_pkg::ST_PY:     if (unit_done) state_d = pdi_pkg::ST_COMMIT;
			pdi_pkg::ST_COMMIT: state_d = pdi_pkg::ST_IDLE;
			default:            state_d = pdi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.op   = pdi_pkg::OP_NONE;
		in_stall = 1'b1;
		case (state_q)
			pdi_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			pdi_pkg::ST_EMIT:   cmd.emit = status.out_free;
			pdi_pkg::ST_COMMIT: cmd.commit = 1'b1;
			default: begin
				case (state_q)
					pdi_pkg::ST_VXX:  cmd.op = pdi_pkg::OP_VXX;
					pdi_pkg::ST_VYY:  cmd.op = pdi_pkg::OP_VYY;
					pdi_pkg::ST_EY:   cmd.op = pdi_pkg::OP_EY;
					pdi_pkg::ST_SQRT: cmd.op = pdi_pkg::OP_SQRT;
					pdi_pkg::ST_P:    cmd.op = pdi_pkg::OP_P;
					pdi_pkg::ST_F:    cmd.op = pdi_pkg::OP_F;
					pdi_pkg::ST_G:    cmd.op = pdi_pkg::OP_G;
					pdi_pkg::ST_TX:   cmd.op = pdi_pkg::OP_TX;
					pdi_pkg::ST_TY:   cmd.op = pdi_pkg::OP_TY;
					pdi_pkg::ST_PX:   cmd.op = pdi_pkg::OP_PX;
					pdi_pkg::ST_PY:   cmd.op = pdi_pkg::OP_PY;
					default:          cmd.op = pdi_pkg::OP_NONE;
				endcase
				cmd.start   = !started_q;
				cmd.capture = started_q && unit_done;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pdi_pkg::ST_IDLE;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start)
				started_q <= 1'b1;
			else if (cmd.capture)
				started_q <= 1'b0;
		end
	end

endmodule

// ----- hdl/pdi_datapath.sv -----
module pdi_datapath (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_write,
	input  logic [pdi_pkg::IDX_BITS-1:0]            cfg_index,
	input  logic [pdi_pkg::CFG_BITS-1:0]            cfg_data,
	input  logic                                    operation,
	input  logic signed [pdi_pkg::WORD_BITS-1:0]    launch_vel_x,
	input  logic signed [pdi_pkg::WORD_BITS-1:0]    launch_vel_y,
	input  pdi_pkg::pdi_cmd_t                       cmd,
	output pdi_pkg::pdi_status_t                    status,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [pdi_pkg::COUNT_BITS-1:0]          step_count,
	output logic signed [pdi_pkg::WORD_BITS-1:0]    pos_x_out,
	output logic signed [pdi_pkg::WORD_BITS-1:0]    pos_y_out,
	output logic signed [pdi_pkg::WORD_BITS-1:0]    vel_x_out,
	output logic signed [pdi_pkg::WORD_BITS-1:0]    vel_y_out,
	output logic signed [pdi_pkg::ENERGY_BITS-1:0]  specific_energy,
	output logic                                    flying,
	output logic signed [pdi_pkg::WORD_BITS-1:0]    peak_height_out,
	output logic signed [pdi_pkg::WORD_BITS-1:0]    peak_distance_out
);
	localparam int W  = pdi_pkg::WORD_BITS;
	localparam int WW = pdi_pkg::WIDE_BITS;
	localparam int MB = pdi_pkg::MUL_BITS;
	localparam int PB = pdi_pkg::PROD_BITS;
	localparam int SB = pdi_pkg::SQ_SUM_BITS;

	logic [pdi_pkg::CFG_BITS-1:0]   gravity_q, time_step_q, drag_q;
	logic signed [W-1:0]            pos_x_q, pos_y_q, vel_x_q, vel_y_q;
	logic signed [W-1:0]            peak_h_q, peak_d_q, nvx_q, nvy_q;
	logic [pdi_pkg::COUNT_BITS-1:0] ticks_q;
	logic                           airborne_q, tick_q, out_valid_q;
	logic [SB-1:0]                  sq_q;
	logic [MB-1:0]                  p_q, f_q;
	logic [pdi_pkg::CFG_BITS-1:0]   gdt_q;
	logic [pdi_pkg::ROOT_BITS-1:0]  speed_q;
	logic [pdi_pkg::ENERGY_BITS-1:0] energy_q;

	logic [MB-1:0]                  mul_a, mul_b;
	logic [PB-1:0]                  prod;
	logic                           mul_start, mul_busy, mul_done;
	logic                           sqrt_start, sqrt_busy, sqrt_done;
	logic [pdi_pkg::ROOT_BITS-1:0]  root;

	logic [W-1:0]                   vx_mag, vy_mag, py_mag;
	logic signed [W:0]              sx, sy;
	logic [W:0]                     sx_mag, sy_mag;
	logic signed [WW-1:0]           ey_s, e_sum;
	logic [MB-1:0]                  term_mag;
	logic signed [W-1:0]            drag_v;
	logic signed [WW-1:0]           term_s, nv_wide;
	logic [pdi_pkg::CFG_BITS-1:0]   drag_sub;
	logic                           s_neg;
	logic signed [WW-1:0]           ps, pd, pos_sum;
	logic signed [W-1:0]            pos_old;

	assign vx_mag = pdi_pkg::mag_word(vel_x_q);
	assign vy_mag = pdi_pkg::mag_word(vel_y_q);
	assign py_mag = pdi_pkg::mag_word(pos_y_q);
	assign sx     = {vel_x_q[W-1], vel_x_q} + {nvx_q[W-1], nvx_q};
	assign sy     = {vel_y_q[W-1], vel_y_q} + {nvy_q[W-1], nvy_q};
	assign sx_mag = sx[W] ? (W+1)'(-sx) : sx;
	assign sy_mag = sy[W] ? (W+1)'(-sy) : sy;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			pdi_pkg::OP_VXX: begin mul_a = MB'(vx_mag);      mul_b = MB'(vx_mag);      end
			pdi_pkg::OP_VYY: begin mul_a = MB'(vy_mag);      mul_b = MB'(vy_mag);      end
			pdi_pkg::OP_EY:  begin mul_a = MB'(py_mag);      mul_b = MB'(gravity_q);   end
			pdi_pkg::OP_P:   begin mul_a = MB'(drag_q);      mul_b = MB'(time_step_q); end
			pdi_pkg::OP_F:   begin mul_a = p_q;              mul_b = MB'(speed_q);     end
			pdi_pkg::OP_G:   begin mul_a = MB'(gravity_q);   mul_b = MB'(time_step_q); end
			pdi_pkg::OP_TX:  begin mul_a = f_q;              mul_b = MB'(vx_mag);      end
			pdi_pkg::OP_TY:  begin mul_a = f_q;              mul_b = MB'(vy_mag);      end
			pdi_pkg::OP_PX:  begin mul_a = MB'(sx_mag);      mul_b = MB'(time_step_q); end
			pdi_pkg::OP_PY:  begin mul_a = MB'(sy_mag);      mul_b = MB'(time_step_q); end
			default:         begin mul_a = '0;               mul_b = '0;               end
		endcase
	end

	assign mul_start  = cmd.start && cmd.op != pdi_pkg::OP_SQRT;
	assign sqrt_start = cmd.start && cmd.op == pdi_pkg::OP_SQRT;

	pdi_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.done   (mul_done),
		.p      (prod)
	);

	pdi_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    ({1'b0, sq_q}),
		.busy   (sqrt_busy),
		.done   (sqrt_done),
		.root   (root)
	);

	// energy: floor(y*g) + floor(|v|^2 / 2)
	assign ey_s  = pos_y_q[W-1] ? -signed'(prod[WW-1:0]) : signed'(prod[WW-1:0]);
	assign e_sum = (ey_s >>> pdi_pkg::G_FRAC)
	             + signed'(WW'(sq_q[SB-1:pdi_pkg::FRAC_BITS+1]));

	// drag: v - sign(v)*floor(f*|v|) - sub
	assign term_mag = prod[pdi_pkg::FACTOR_FRAC+MB-1:pdi_pkg::FACTOR_FRAC];
	assign drag_v   = (cmd.op == pdi_pkg::OP_TY) ? vel_y_q : vel_x_q;
	assign drag_sub = (cmd.op == pdi_pkg::OP_TY) ? gdt_q : '0;
	assign term_s   = drag_v[W-1] ? -signed'(WW'(term_mag)) : signed'(WW'(term_mag));
	assign nv_wide  = {{(WW-W){drag_v[W-1]}}, drag_v} - term_s - signed'(WW'(drag_sub));

	// position: p + floor((v_old + v_new) * dt / 2)
	assign s_neg   = (cmd.op == pdi_pkg::OP_PY) ? sy[W] : sx[W];
	assign ps      = s_neg ? -signed'(prod[WW-1:0]) : signed'(prod[WW-1:0]);
	assign pd      = ps >>> (pdi_pkg::DT_FRAC + 1);
	assign pos_old = (cmd.op == pdi_pkg::OP_PY) ? pos_y_q : pos_x_q;
	assign pos_sum = {{(WW-W){pos_old[W-1]}}, pos_old} + pd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q   <= pdi_pkg::GRAVITY_RST;
			time_step_q <= pdi_pkg::TIME_STEP_RST;
			drag_q      <= pdi_pkg::DRAG_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				pdi_pkg::REG_GRAVITY:   gravity_q   <= cfg_data;
				pdi_pkg::REG_TIME_STEP: time_step_q <= cfg_data;
				pdi_pkg::REG_DRAG:      drag_q      <= cfg_data;
				default:                ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			vel_x_q     <= '0;
			vel_y_q     <= '0;
			peak_h_q    <= '0;
			peak_d_q    <= '0;
			ticks_q     <= '0;
			airborne_q  <= 1'b0;
			tick_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				tick_q <= operation;
				if (operation == pdi_pkg::IN_LAUNCH) begin
					vel_x_q    <= launch_vel_x;
					vel_y_q    <= launch_vel_y;
					pos_x_q    <= '0;
					pos_y_q    <= '0;
					peak_h_q   <= '0;
					peak_d_q   <= '0;
					ticks_q    <= '0;
					airborne_q <= 1'b1;
				end
			end
			if (cmd.capture && cmd.op == pdi_pkg::OP_PX)
				pos_x_q <= pdi_pkg::sat_word(pos_sum);
			if (cmd.capture && cmd.op == pdi_pkg::OP_PY)
				pos_y_q <= pdi_pkg::sat_word(pos_sum);
			if (cmd.commit) begin
				vel_x_q <= nvx_q;
				vel_y_q <= nvy_q;
				if (ticks_q != '1)
					ticks_q <= ticks_q + pdi_pkg::COUNT_BITS'(1);
				if (pos_y_q > peak_h_q) begin
					peak_h_q <= pos_y_q;
					peak_d_q <= pos_x_q;
				end
				if (pos_y_q[W-1])
					airborne_q <= 1'b0;
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			case (cmd.op)
				pdi_pkg::OP_VXX:  sq_q     <= SB'(prod[2*W-1:0]);
				pdi_pkg::OP_VYY:  sq_q     <= sq_q + SB'(prod[2*W-1:0]);
				pdi_pkg::OP_EY:   energy_q <= pdi_pkg::sat_energy(e_sum);
				pdi_pkg::OP_SQRT: speed_q  <= root;
				pdi_pkg::OP_P:    p_q      <= prod[MB-1:0];
				pdi_pkg::OP_F:    f_q      <= (prod[PB-1:pdi_pkg::FACTOR_FRAC+MB] != '0) ?
				                              '1 : term_mag;
				pdi_pkg::OP_G:    gdt_q    <= prod[pdi_pkg::G_FRAC+pdi_pkg::DT_FRAC
				                              -pdi_pkg::FRAC_BITS+pdi_pkg::CFG_BITS-1:
				                              pdi_pkg::G_FRAC+pdi_pkg::DT_FRAC-pdi_pkg::FRAC_BITS];
				pdi_pkg::OP_TX:   nvx_q    <= pdi_pkg::sat_word(nv_wide);
				pdi_pkg::OP_TY:   nvy_q    <= pdi_pkg::sat_word(nv_wide);
				default:          ;
			endcase
		end
		if (cmd.emit) begin
			step_count        <= ticks_q;
			pos_x_out         <= pos_x_q;
			pos_y_out         <= pos_y_q;
			vel_x_out         <= vel_x_q;
			vel_y_out         <= vel_y_q;
			specific_energy   <= energy_q;
			flying            <= airborne_q;
			peak_height_out   <= peak_h_q;
			peak_distance_out <= peak_d_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign status.mul_done  = mul_done;
	assign status.sqrt_done = sqrt_done;
	assign status.out_free  = !out_valid_q || !out_stall;
	assign status.advance   = tick_q && airborne_q;

	a_mul_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_busy)
		else $error("multiplier restarted while busy");

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_busy && sqrt_busy))
		else $error("multiplier and root unit active together");

	a_landed_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(!airborne_q && !cmd.load) |=> $stable(pos_y_q))
		else $error("height moved while not airborne");

endmodule

// ----- hdl/projectile_drag_integrator_unit.sv -----
// Launch, or tick before launch or after landing: three multiplies, then the emit;
// next word taken in the cycle after the emit, so one word is handled at a time.
// Tick while airborne: result emitted after the same steps; next word taken only after
// the root, seven more multiplies and the commit.
// One shared 32x32 multiplier and one bit-serial root; output stall holds the emit.
// Reset (arst_n low, asynchronous): state cleared, registers at defaults.
module projectile_drag_integrator_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_write,
	input  logic [pdi_pkg::IDX_BITS-1:0]            cfg_index,
	input  logic [pdi_pkg::CFG_BITS-1:0]            cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic                                    operation,
	input  logic signed [pdi_pkg::WORD_BITS-1:0]    launch_vel_x,
	input  logic signed [pdi_pkg::WORD_BITS-1:0]    launch_vel_y,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [pdi_pkg::COUNT_BITS-1:0]          step_count,
	output logic signed [pdi_pkg::WORD_BITS-1:0]    pos_x_out,
	output logic signed [pdi_pkg::WORD_BITS-1:0]    pos_y_out,
	output logic signed [pdi_pkg::WORD_BITS-1:0]    vel_x_out,
	output logic signed [pdi_pkg::WORD_BITS-1:0]    vel_y_out,
	output logic signed [pdi_pkg::ENERGY_BITS-1:0]  specific_energy,
	output logic                                    flying,
	output logic signed [pdi_pkg::WORD_BITS-1:0]    peak_height_out,
	output logic signed [pdi_pkg::WORD_BITS-1:0]    peak_distance_out
);
	pdi_pkg::pdi_cmd_t    cmd;
	pdi_pkg::pdi_status_t status;

	pdi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	pdi_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.operation         (operation),
		.launch_vel_x      (launch_vel_x),
		.launch_vel_y      (launch_vel_y),
		.cmd               (cmd),
		.status            (status),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.step_count        (step_count),
		.pos_x_out         (pos_x_out),
		.pos_y_out         (pos_y_out),
		.vel_x_out         (vel_x_out),
		.vel_y_out         (vel_y_out),
		.specific_energy   (specific_energy),
		.flying            (flying),
		.peak_height_out   (peak_height_out),
		.peak_distance_out (peak_distance_out)
	);

endmodule

// ----- tb/pdi_flight_checker.sv -----
module pdi_flight_checker
	import pdi_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [IDX_BITS-1:0]           cfg_index,
	input  logic [CFG_BITS-1:0]           cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          operation,
	input  logic signed [WORD_BITS-1:0]   launch_vel_x,
	input  logic signed [WORD_BITS-1:0]   launch_vel_y,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [COUNT_BITS-1:0]         step_count,
	input  logic signed [WORD_BITS-1:0]   pos_x_out,
	input  logic signed [WORD_BITS-1:0]   pos_y_out,
	input  logic signed [WORD_BITS-1:0]   vel_x_out,
	input  logic signed [WORD_BITS-1:0]   vel_y_out,
	input  logic signed [ENERGY_BITS-1:0] specific_energy,
	input  logic                          flying,
	input  logic signed [WORD_BITS-1:0]   peak_height_out,
	input  logic signed [WORD_BITS-1:0]   peak_distance_out,
	output int                            errors,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [255:0] big_t;

	typedef struct {
		logic [COUNT_BITS-1:0]         cnt;
		logic signed [WORD_BITS-1:0]   px, py, vx, vy;
		logic signed [ENERGY_BITS-1:0] energy;
		logic                          fly;
		logic signed [WORD_BITS-1:0]   pk_h, pk_d;
	} flight_word_t;

	flight_word_t report_q[$];

	logic [CFG_BITS-1:0]         grav, dt, drag;
	logic signed [WORD_BITS-1:0] px, py, vx, vy, pk_h, pk_d;
	logic [COUNT_BITS-1:0]       steps;
	logic                        aloft;

	function automatic big_t clamp(big_t v, int w);
		big_t hi = (big_t'(1) <<< (w - 1)) - 1;
		big_t lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic logic [63:0] root(logic [127:0] n);
		logic [63:0]  r = '0;
		logic [127:0] c;
		for (int b = 63; b >= 0; b--) begin
			c = {64'd0, r | (64'd1 << b)};
			if (c * c <= n)
				r = c[63:0];
		end
		return r;
	endfunction

	function automatic logic signed [WORD_BITS-1:0] drag_vel(logic signed [WORD_BITS-1:0] v,
			logic [63:0] f, logic [63:0] sub);
		big_t mv = (v < 0) ? -big_t'(v) : big_t'(v);
		big_t term = (big_t'(f) * mv) >>> FACTOR_FRAC;
		if (v < 0)
			term = -term;
		return WORD_BITS'(clamp(big_t'(v) - term - big_t'(sub), WORD_BITS));
	endfunction

	function automatic big_t speed_sq();
		return big_t'(vx) * big_t'(vx) + big_t'(vy) * big_t'(vy);
	endfunction

	function automatic void advance_flight();
		logic [63:0] speed = root(128'(speed_sq()));
		logic [63:0] p = {32'd0, drag} * {32'd0, dt};
		big_t fw = (big_t'(p) * big_t'(speed)) >>> (DRAG_FRAC + DT_FRAC + FRAC_BITS - FACTOR_FRAC);
		logic [63:0] f = (fw > big_t'(64'hFFFF_FFFF_FFFF_FFFF)) ? '1 : fw[63:0];
		logic [63:0] gdt = ({32'd0, grav} * {32'd0, dt}) >> (G_FRAC + DT_FRAC - FRAC_BITS);
		logic signed [WORD_BITS-1:0] nvx = drag_vel(vx, f, 64'd0);
		logic signed [WORD_BITS-1:0] nvy = drag_vel(vy, f, gdt);
		px = WORD_BITS'(clamp(big_t'(px) +
			(((big_t'(vx) + big_t'(nvx)) * big_t'(dt)) >>> (DT_FRAC + 1)), WORD_BITS));
		py = WORD_BITS'(clamp(big_t'(py) +
			(((big_t'(vy) + big_t'(nvy)) * big_t'(dt)) >>> (DT_FRAC + 1)), WORD_BITS));
		vx = nvx;
		vy = nvy;
		if (steps != '1)
			steps++;
		if (py > pk_h) begin
			pk_h = py;
			pk_d = px;
		end
		if (py < 0)
			aloft = 1'b0;
	endfunction

	function automatic flight_word_t take_word(logic op, logic signed [WORD_BITS-1:0] lx,
			logic signed [WORD_BITS-1:0] ly);
		flight_word_t w;
		if (op == IN_LAUNCH) begin
			vx = lx;
			vy = ly;
			px = '0;
			py = '0;
			pk_h = '0;
			pk_d = '0;
			steps = '0;
			aloft = 1'b1;
		end
		w.cnt = steps;
		w.px = px;
		w.py = py;
		w.vx = vx;
		w.vy = vy;
		w.energy = ENERGY_BITS'(clamp(((big_t'(py) * big_t'(grav)) >>> G_FRAC) +
			(speed_sq() >>> (FRAC_BITS + 1)), ENERGY_BITS));
		w.fly = aloft;
		w.pk_h = pk_h;
		w.pk_d = pk_d;
		if (op == IN_TICK && aloft)
			advance_flight();
		return w;
	endfunction

	task automatic mismatch(string name, logic [63:0] want, logic [63:0] got);
		$display("%t mismatch %s: expected %h actual %h", $time, name, want, got);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		flight_word_t w;
		if (!arst_n) begin
			grav = GRAVITY_RST;
			dt = TIME_STEP_RST;
			drag = DRAG_RST;
			px = '0; py = '0; vx = '0; vy = '0; pk_h = '0; pk_d = '0;
			steps = '0;
			aloft = 1'b0;
			report_q.delete();
			errors = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (report_q.size() == 0) begin
					$display("%t unexpected result word, step_count %h", $time, step_count);
					errors++;
				end else begin
					w = report_q.pop_front();
					if (step_count !== w.cnt) mismatch("step_count", w.cnt, step_count);
					if (pos_x_out !== w.px) mismatch("pos_x_out", w.px, pos_x_out);
					if (pos_y_out !== w.py) mismatch("pos_y_out", w.py, pos_y_out);
					if (vel_x_out !== w.vx) mismatch("vel_x_out", w.vx, vel_x_out);
					if (vel_y_out !== w.vy) mismatch("vel_y_out", w.vy, vel_y_out);
					if (specific_energy !== w.energy)
						mismatch("specific_energy", w.energy, specific_energy);
					if (flying !== w.fly) mismatch("flying", w.fly, flying);
					if (peak_height_out !== w.pk_h)
						mismatch("peak_height_out", w.pk_h, peak_height_out);
					if (peak_distance_out !== w.pk_d)
						mismatch("peak_distance_out", w.pk_d, peak_distance_out);
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_GRAVITY:   grav = cfg_data;
					REG_TIME_STEP: dt = cfg_data;
					REG_DRAG:      drag = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				report_q.push_back(take_word(operation, launch_vel_x, launch_vel_y));
		end
		pending = report_q.size();
	end

endmodule

// ----- tb/tb.sv -----
module tb;
	import pdi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_write;
	logic [IDX_BITS-1:0]           cfg_index;
	logic [CFG_BITS-1:0]           cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic                          operation;
	logic signed [WORD_BITS-1:0]   launch_vel_x;
	logic signed [WORD_BITS-1:0]   launch_vel_y;
	logic                          out_valid;
	logic                          out_stall;
	logic [COUNT_BITS-1:0]         step_count;
	logic signed [WORD_BITS-1:0]   pos_x_out, pos_y_out, vel_x_out, vel_y_out;
	logic signed [ENERGY_BITS-1:0] specific_energy;
	logic                          flying;
	logic signed [WORD_BITS-1:0]   peak_height_out, peak_distance_out;
	int                            errors;
	int                            pending;

	int send_idle;
	int recv_stall;
	int hold_cycles;

	projectile_drag_integrator_unit i_dut (.*);

	pdi_flight_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("[projectile_drag_integrator_unit] ERROR");
		$finish;
	end

	// receiver side; a long hold-off lets the block back up into its input
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else
				out_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	task automatic send(logic op, logic signed [WORD_BITS-1:0] lx,
			logic signed [WORD_BITS-1:0] ly);
		in_valid <= 1'b1;
		operation <= op;
		launch_vel_x <= lx;
		launch_vel_y <= ly;
		do @(posedge clk); while (in_stall);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic logic signed [WORD_BITS-1:0] pick_vel();
		if ($urandom_range(9) == 0)
			return WORD_BITS'({$urandom, $urandom});
		return WORD_BITS'(longint'($urandom_range(0, 32'd2013265920)) - 64'sd1006632960);
	endfunction

	localparam logic signed [WORD_BITS-1:0] VMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic signed [WORD_BITS-1:0] VMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic signed [WORD_BITS-1:0] V5   = 48'sd83886080;

	initial begin
		logic [CFG_BITS-1:0] gset[6], tset[6], dset[6];
		int sent, flight;
		gset = '{GRAVITY_RST, 32'd164584489, '1, '0, 32'd0, GRAVITY_RST};
		tset = '{TIME_STEP_RST, 32'd214748365, '1, '0, 32'd0, 32'd429496730};
		dset = '{DRAG_RST, DRAG_RST, '1, '0, 32'd0, '1};
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = IN_TICK;
		launch_vel_x = '0;
		launch_vel_y = '0;
		send_idle = 0;
		recv_stall = 0;
		hold_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset-state tick, extremes, landing and frozen state
		send(IN_TICK, '0, '0);
		send(IN_LAUNCH, VMAX, VMAX);
		send(IN_TICK, '0, '0);
		send(IN_TICK, '0, '0);
		send(IN_LAUNCH, VMIN, VMIN);
		send(IN_TICK, VMAX, VMAX);
		send(IN_LAUNCH, VMAX, VMIN);
		send(IN_TICK, '0, '0);
		send(IN_LAUNCH, '0, '0);
		send(IN_TICK, '0, '0);
		send(IN_TICK, '0, '0);
		send(IN_LAUNCH, V5, -48'sd1);
		send(IN_TICK, '0, '0);
		send(IN_TICK, '0, '0);
		send(IN_TICK, '0, '0);
		send(IN_LAUNCH, V5, V5);
		repeat (5) send(IN_TICK, VMIN, VMAX);

		for (int ph = 0; ph < 6; ph++) begin
			settle();
			if (ph == 4) begin
				gset[4] = $urandom;
				tset[4] = $urandom;
				dset[4] = $urandom;
			end
			write_reg(REG_GRAVITY, gset[ph]);
			write_reg(REG_TIME_STEP, tset[ph]);
			write_reg(REG_DRAG, dset[ph]);
			send_idle = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 52 : 15) : 0;
			recv_stall = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 2) ? 52 : 15) : 0;
			if (ph == 1)
				hold_cycles = 3000;
			sent = 0;
			while (sent < 250) begin
				if ($urandom_range(9) == 0) begin
					send($urandom_range(1), pick_vel(), pick_vel());
					sent++;
				end else begin
					send(IN_LAUNCH, pick_vel(), pick_vel());
					flight = $urandom_range(1, 60);
					for (int k = 0; k < flight; k++)
						send(IN_TICK, pick_vel(), pick_vel());
					sent += flight + 1;
				end
			end
		end

		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("[projectile_drag_integrator_unit] OK");
		else
			$display("[projectile_drag_integrator_unit] ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/pdi_pkg.sv
hdl/pdi_mul.sv
hdl/pdi_sqrt.sv
hdl/pdi_ctrl.sv
hdl/pdi_datapath.sv
hdl/projectile_drag_integrator_unit.sv
tb/pdi_flight_checker.sv
tb/tb.sv
